// ----- rtl/lrup_pkg.sv -----
`timescale 1ns / 1ps

package lrup_pkg;

    localparam int ENTRIES   = 16;
    localparam int PAGE_BITS = 16;

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W = IDX_W;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int CFG_W  = 5;
    localparam int CMP_W  = (CFG_W > CNT_W) ? CFG_W : CNT_W;

    // result item field widths
    localparam int SLOT_W  = 4;
    localparam int EPAGE_W = 16;
    localparam int OUT_W   = 1 + SLOT_W + 1 + EPAGE_W;
    localparam int M_DATA_W = ((OUT_W + 7) / 8) * 8;
    localparam int S_DATA_W = ((PAGE_BITS + 7) / 8) * 8;

    localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(ENTRIES - 1);

    // running search record handed from cell to cell
    typedef struct packed {
        logic                 hit;
        logic [IDX_W-1:0]     hit_slot;
        logic [RANK_W-1:0]    hit_rank;
        logic                 empty;
        logic [IDX_W-1:0]     empty_slot;
        logic [RANK_W-1:0]    best_rank;
        logic [IDX_W-1:0]     best_slot;
        logic [PAGE_BITS-1:0] best_page;
    } search_t;

    // update broadcast to every cell
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  slot;
        logic              write_page;
        logic              age_all;
        logic [RANK_W-1:0] thr;
    } update_t;

endpackage

// ----- rtl/lrup_cell.sv -----
`timescale 1ns / 1ps

module lrup_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [lrup_pkg::IDX_W-1:0]    cell_idx,
    input  logic                          active,
    input  logic [lrup_pkg::PAGE_BITS-1:0] key,
    input  lrup_pkg::search_t             rec_in,
    output lrup_pkg::search_t             rec_out,
    input  lrup_pkg::update_t             upd
);
    import lrup_pkg::*;

    logic [PAGE_BITS-1:0] page_reg;
    logic                 valid_reg;
    logic [RANK_W-1:0]    rank_reg;

    always_comb begin
        rec_out = rec_in;
        if (active) begin
            if (valid_reg && (page_reg == key) && !rec_in.hit) begin
                rec_out.hit      = 1'b1;
                rec_out.hit_slot = cell_idx;
                rec_out.hit_rank = rank_reg;
            end
            if (!valid_reg && !rec_in.empty) begin
                rec_out.empty      = 1'b1;
                rec_out.empty_slot = cell_idx;
            end
            // strict compare keeps the lowest index on equal ranks
            if ((cell_idx == '0) || (rank_reg > rec_in.best_rank)) begin
                rec_out.best_rank = rank_reg;
                rec_out.best_slot = cell_idx;
                rec_out.best_page = page_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end else if (upd.we && active) begin
            if (upd.slot == cell_idx) begin
                rank_reg <= '0;
                if (upd.write_page) begin
                    valid_reg <= 1'b1;
                end
            end else if (valid_reg && (upd.age_all || (rank_reg < upd.thr))
                         && (rank_reg != RANK_MAX)) begin
                rank_reg <= rank_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (upd.we && active && (upd.slot == cell_idx) && upd.write_page) begin
            page_reg <= key;
        end
    end

endmodule

// ----- rtl/lru_page_replacement.sv -----
`timescale 1ns / 1ps

// LRU page replacement over a fully associative store of ENTRIES frames.
// s_ channel: one page reference per item, s_tdata[15:0] = page.
// m_ channel: one result per reference: hit flag, slot now holding the page,
// evicted flag and the evicted page (zero when nothing was evicted).
// cfg_wen/cfg_wdata set the number of frames in use; write it only when idle.
// Each reference is matched by a row of ENTRIES cells; a search record
// walks the row one cell per cycle. An item passes through accept, the walk
// of the row and the update cycle; the next item is taken once the update
// cycle has passed. The result is registered in the update cycle and then
// shown on m_tvalid.
// The result sits in an output register; while the receiver stalls, the
// block still accepts and searches the next item, and holds in its update
// cycle until the output register is free.
// Reset (aresetn low, synchronous) empties all frames, clears all ranks
// and sets the frame count to 16.
module lru_page_replacement (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [lrup_pkg::S_DATA_W-1:0]  s_tdata,  // [15:0] page
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] hit, [4:1] slot, [5] evicted, [21:6] evicted_page, [23:22] zero
    output logic [lrup_pkg::M_DATA_W-1:0]  m_tdata,
    input  logic                           cfg_wen,
    input  logic [lrup_pkg::CFG_W-1:0]     cfg_wdata
);
    import lrup_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_UPDATE
    } state_t;

    state_t               state_reg;
    logic [IDX_W-1:0]     cnt_reg;
    logic [PAGE_BITS-1:0] key_reg;
    logic [CFG_W-1:0]     cfg_reg;
    logic                 m_valid_reg;
    logic [M_DATA_W-1:0]  m_data_reg;

    logic [CMP_W-1:0]     cfg_ext;
    logic [CMP_W-1:0]     n_eff;
    logic [ENTRIES-1:0]   active;

    search_t              rec_reg [ENTRIES];
    search_t              rec_in  [ENTRIES];
    search_t              rec_out [ENTRIES];
    search_t              rec_init;
    search_t              res;
    update_t              upd;
    logic                 out_free;
    logic                 evict;
    logic [IDX_W-1:0]     res_slot;
    logic [PAGE_BITS-1:0] res_epage;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_W'(16);
        end else if (cfg_wen) begin
            cfg_reg <= cfg_wdata;
        end
    end

    // zero acts as one frame, anything above ENTRIES as ENTRIES
    always_comb begin
        cfg_ext = CMP_W'(cfg_reg);
        if (cfg_ext == '0) begin
            n_eff = CMP_W'(1);
        end else if (cfg_ext > CMP_W'(ENTRIES)) begin
            n_eff = CMP_W'(ENTRIES);
        end else begin
            n_eff = cfg_ext;
        end
    end

    always_comb begin
        rec_init = '0;
    end

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
            assign active[gi] = (CMP_W'(gi) < n_eff);
            if (gi == 0) begin : g_first
                assign rec_in[gi] = rec_init;
            end else begin : g_next
                assign rec_in[gi] = rec_reg[gi-1];
            end

            lrup_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .cell_idx (IDX_W'(gi)),
                .active   (active[gi]),
                .key      (key_reg),
                .rec_in   (rec_in[gi]),
                .rec_out  (rec_out[gi]),
                .upd      (upd)
            );

            always_ff @(posedge aclk) begin
                rec_reg[gi] <= rec_out[gi];
            end
        end
    endgenerate

    assign res      = rec_reg[ENTRIES-1];
    assign out_free = !m_valid_reg || m_tready;
    assign evict    = !res.hit && !res.empty;

    always_comb begin
        if (res.hit) begin
            res_slot = res.hit_slot;
        end else if (res.empty) begin
            res_slot = res.empty_slot;
        end else begin
            res_slot = res.best_slot;
        end
        res_epage = evict ? res.best_page : '0;

        upd.we         = (state_reg == ST_UPDATE) && out_free;
        upd.slot       = res_slot;
        upd.write_page = !res.hit;
        upd.age_all    = !res.hit && res.empty;
        upd.thr        = res.hit ? res.hit_rank : res.best_rank;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // a new result replaces the one leaving in the same cycle
            if (upd.we) begin
                m_valid_reg <= 1'b1;
                m_data_reg  <= M_DATA_W'({EPAGE_W'(res_epage), evict,
                                          SLOT_W'(res_slot), res.hit});
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        key_reg   <= s_tdata[PAGE_BITS-1:0];
                        cnt_reg   <= '0;
                        state_reg <= ST_SWEEP;
                    end
                end
                ST_SWEEP: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == IDX_W'(ENTRIES - 1)) begin
                        state_reg <= ST_UPDATE;
                    end
                end
                ST_UPDATE: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
